[hdl/tkce_pkg.sv]
// shared types and constants for the touch keypad code entry block
package tkce_pkg;

    localparam int NUM_KEYS   = 12;
    localparam int MAX_LENGTH = 8;

    localparam int KEY_W    = 4;
    localparam int LEN_W    = 4;
    localparam int CODE_W   = 25;
    localparam int TIME_W   = 32;
    localparam int SHORT_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef logic [KEY_W-1:0] key_t;

    localparam key_t KEY_ZERO  = key_t'(9);
    localparam key_t KEY_CLEAR = key_t'(10);
    localparam key_t KEY_ENTER = key_t'(11);
    localparam key_t NO_KEY    = key_t'(12);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_BEEP     = 2'd1,
        REG_ZERO_DLY = 2'd2,
        REG_SLEEP    = 2'd3
    } cfg_reg_t;

    localparam logic [SHORT_W-1:0] DEBOUNCE_RST = 16'd100;
    localparam logic [SHORT_W-1:0] BEEP_RST     = 16'd20;
    localparam logic [SHORT_W-1:0] ZERO_DLY_RST = 16'd2000;
    localparam logic [TIME_W-1:0]  SLEEP_RST    = 32'd10000;

    // one scan result, packed lowest field last so it maps onto tdata
    typedef struct packed {
        logic              sleep_request;
        logic              buzzer_on;
        logic              zero_report;
        logic [CODE_W-1:0] code_value;
        logic              code_valid;
        key_t              accepted_key;
    } result_t;

    // lowest set bit of a touch edge vector, NO_KEY if none
    function automatic key_t lowest_key(input logic [NUM_KEYS-1:0] edges);
        key_t k;
        k = NO_KEY;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (edges[i])
            begin
                k = key_t'(i);
            end
        end
        return k;
    endfunction

endpackage

[hdl/touch_keypad_code_entry_top.sv]
// top level of the touch keypad code entry block
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  ------------------------------------
//  scan in   in   s_tvalid / s_tready       s_tdata: touch_state, now_ms
//  result    out  m_tvalid / m_tready       m_tdata: key, code, flags (see port)
//  config    in   cfg_wr_en (no wait)       cfg_addr, cfg_wdata
//
//  one scan transaction per clock when the result side keeps taking; a scan sits
//  in the input register, where the edge, debounce, entry and timer logic runs
//  against the state registers, and lands in the result register
//  reset (rst_n low, async) restores the register defaults, empties both
//  stages and sets the entry to the lead digit 1
//  a stalled result holds the result register; the input register keeps one
//  scan waiting behind it and s_tready drops until the result is taken
module touch_keypad_code_entry_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // scan transaction
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tkce_pkg::IN_TDATA_W-1:0]   s_tdata,  // [11:0] touch_state, [43:12] now_ms
    // result transaction
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tkce_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [3:0] accepted_key, [4] code_valid,
                                                        // [29:5] code_value, [30] zero_report,
                                                        // [31] buzzer_on, [32] sleep_request
    // register writes
    input  logic                              cfg_wr_en,
    input  logic [tkce_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [tkce_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int TW = tkce_pkg::TIME_W;
    localparam int CW = tkce_pkg::CODE_W;
    localparam int SW = tkce_pkg::SHORT_W;
    localparam int NK = tkce_pkg::NUM_KEYS;
    localparam int LW = tkce_pkg::LEN_W;

    // configuration registers
    logic [SW-1:0] debounce_reg;
    logic [SW-1:0] beep_reg;
    logic [SW-1:0] zero_dly_reg;
    logic [TW-1:0] sleep_reg;

    // input stage
    logic          in_valid_reg;
    logic [NK-1:0] in_touch_reg;
    logic [TW-1:0] in_now_reg;

    // result stage
    logic                 out_valid_reg;
    tkce_pkg::result_t    out_res_reg;
    tkce_pkg::result_t    res_next;

    // scan state
    logic [NK-1:0] prev_touch_reg,  prev_touch_next;
    logic [TW-1:0] last_press_reg,  last_press_next;
    logic [TW-1:0] activity_reg,    activity_next;
    logic [TW-1:0] beep_start_reg,  beep_start_next;
    logic          beep_active_reg, beep_active_next;
    logic [CW-1:0] entry_reg,       entry_next;
    logic [LW-1:0] entry_len_reg,   entry_len_next;
    logic [TW-1:0] enter_time_reg,  enter_time_next;
    logic          zero_pend_reg,   zero_pend_next;

    logic          advance;
    logic          process;
    logic [NK-1:0] rising;
    tkce_pkg::key_t first_key;
    logic          any_edge;
    logic          accept;
    logic [LW-1:0] digit;
    logic [CW-1:0] entry_shift;
    logic          beep_pre;
    logic [TW-1:0] beep_start_pre;
    logic          zero_pend_pre;
    logic [TW-1:0] enter_time_pre;

    // the result register frees when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tkce_pkg::OUT_TDATA_W - $bits(tkce_pkg::result_t)){1'b0}}, out_res_reg};

    // only the lowest new edge can pass debounce: once it is taken the
    // press time equals now and nothing else in the scan clears the window
    assign rising      = in_touch_reg & ~prev_touch_reg;
    assign first_key   = tkce_pkg::lowest_key(rising);
    assign any_edge    = |rising;
    assign accept      = any_edge && ((in_now_reg - last_press_reg) > {16'd0, debounce_reg});
    assign digit       = (first_key == tkce_pkg::KEY_ZERO) ? '0 : first_key + 4'd1;
    // times ten as two shifts and an add, kept modulo the entry width
    assign entry_shift = {entry_reg[CW-4:0], 3'b000} + {entry_reg[CW-2:0], 1'b0};

    always_comb
    begin
        prev_touch_next = in_touch_reg;
        last_press_next = last_press_reg;
        activity_next   = any_edge ? in_now_reg : activity_reg;
        beep_start_pre  = beep_start_reg;
        beep_pre        = beep_active_reg;
        entry_next      = entry_reg;
        entry_len_next  = entry_len_reg;
        enter_time_pre  = enter_time_reg;
        zero_pend_pre   = zero_pend_reg;
        res_next.accepted_key = tkce_pkg::NO_KEY;
        res_next.code_valid   = 1'b0;
        res_next.code_value   = '0;

        if (accept)
        begin
            res_next.accepted_key = first_key;
            last_press_next = in_now_reg;
            beep_pre        = 1'b1;
            beep_start_pre  = in_now_reg;
            case (first_key)
                tkce_pkg::KEY_CLEAR:
                begin
                    entry_next     = CW'(1);
                    entry_len_next = LW'(1);
                end
                tkce_pkg::KEY_ENTER:
                begin
                    res_next.code_valid = 1'b1;
                    res_next.code_value = entry_reg;
                    enter_time_pre      = in_now_reg;
                    zero_pend_pre       = 1'b1;
                    entry_next          = CW'(1);
                    entry_len_next      = LW'(1);
                end
                default:
                begin
                    // full entry still beeps but keeps its digits
                    if (entry_len_reg < LW'(tkce_pkg::MAX_LENGTH))
                    begin
                        entry_next     = entry_shift + {{(CW-LW){1'b0}}, digit};
                        entry_len_next = entry_len_reg + LW'(1);
                    end
                end
            endcase
        end

        // buzzer end after key handling, zero report after buzzer
        beep_start_next  = beep_start_pre;
        beep_active_next = beep_pre && !((in_now_reg - beep_start_pre) >= {16'd0, beep_reg});
        enter_time_next  = enter_time_pre;
        res_next.zero_report = zero_pend_pre
                               && ((in_now_reg - enter_time_pre) >= {16'd0, zero_dly_reg});
        zero_pend_next   = zero_pend_pre && !res_next.zero_report;
        res_next.buzzer_on     = beep_active_next;
        res_next.sleep_request = (in_now_reg - activity_next) > sleep_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= tkce_pkg::DEBOUNCE_RST;
            beep_reg     <= tkce_pkg::BEEP_RST;
            zero_dly_reg <= tkce_pkg::ZERO_DLY_RST;
            sleep_reg    <= tkce_pkg::SLEEP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (tkce_pkg::cfg_reg_t'(cfg_addr))
                tkce_pkg::REG_DEBOUNCE: debounce_reg <= cfg_wdata[SW-1:0];
                tkce_pkg::REG_BEEP:     beep_reg     <= cfg_wdata[SW-1:0];
                tkce_pkg::REG_ZERO_DLY: zero_dly_reg <= cfg_wdata[SW-1:0];
                tkce_pkg::REG_SLEEP:    sleep_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage and result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_touch_reg <= s_tdata[NK-1:0];
            in_now_reg   <= s_tdata[NK+TW-1:NK];
        end
        if (process)
        begin
            out_res_reg <= res_next;
        end
    end

    // scan state, updated once per processed scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_touch_reg  <= '0;
            last_press_reg  <= '0;
            activity_reg    <= '0;
            beep_start_reg  <= '0;
            beep_active_reg <= 1'b0;
            entry_reg       <= CW'(1);
            entry_len_reg   <= LW'(1);
            enter_time_reg  <= '0;
            zero_pend_reg   <= 1'b0;
        end
        else if (process)
        begin
            prev_touch_reg  <= prev_touch_next;
            last_press_reg  <= last_press_next;
            activity_reg    <= activity_next;
            beep_start_reg  <= beep_start_next;
            beep_active_reg <= beep_active_next;
            entry_reg       <= entry_next;
            entry_len_reg   <= entry_len_next;
            enter_time_reg  <= enter_time_next;
            zero_pend_reg   <= zero_pend_next;
        end
    end

    // entry length stays within one lead digit and the full length
    a_entry_len: assert property (@(posedge clk) disable iff (!rst_n)
        entry_len_reg >= LW'(1) && entry_len_reg <= LW'(tkce_pkg::MAX_LENGTH))
        else $error("entry length out of range");

    // a reported code always comes with the enter key
    a_code_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.code_valid |-> out_res_reg.accepted_key == tkce_pkg::KEY_ENTER)
        else $error("code reported without enter key");

    // the code field is zero unless a code is reported
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.code_valid |-> out_res_reg.code_value == '0)
        else $error("code value set without code valid");

    // a waiting scan does not touch the state while the result stalls
    a_stall_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> $stable(entry_reg) && $stable(prev_touch_reg))
        else $error("state changed during stall");

endmodule
